// File: design/mbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int DIM_W       = $clog2(MAX_DIM);       // counter / coordinate width
    localparam int CFG_DIM_W   = 13;                    // width/height register width
    localparam int CFG_W       = 13;                    // widest register
    localparam int CFG_IDX_W   = 3;
    localparam int PIX_PER_BYTE = 8;
    localparam int CNT_W       = $clog2(PIX_PER_BYTE + 1);
    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] COLOR_SET       = 16'hFFFF;
    localparam logic [15:0] COLOR_CLEAR_565 = 16'h0000;
    localparam logic [15:0] COLOR_CLEAR_1555 = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLOR_FORMAT = 3'd0,
        REG_IMAGE_WIDTH  = 3'd1,
        REG_IMAGE_HEIGHT = 3'd2,
        REG_PAD_BYTES    = 3'd3,
        REG_FLIP_ROWS    = 3'd4
    } reg_idx_t;

    // one classified source byte, handed from front to back
    typedef struct packed {
        logic [7:0]       src_bits;
        logic [CNT_W-1:0] pix_count;   // 1..8
        logic [DIM_W-1:0] col_start;
        logic [DIM_W-1:0] row_out;
        logic             frame_last;  // final pixel of this byte ends the frame
    } desc_t;

    function automatic logic [CFG_DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
        logic [CFG_DIM_W-1:0] r;
        if (v == '0) begin
            r = CFG_DIM_W'(1);
        end else if (v > CFG_DIM_W'(MAX_DIM)) begin
            r = CFG_DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/mbe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mbe_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mbe_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_source_byte,
    output logic                                color_format,
    input  wire logic                           q_full,
    output logic                                q_push,
    output mbe_pkg::desc_t                      q_wdata
);

    localparam int DW  = mbe_pkg::DIM_W;
    localparam int CDW = mbe_pkg::CFG_DIM_W;

    logic           color_format_reg;
    logic [CDW-1:0] image_width_reg;
    logic [CDW-1:0] image_height_reg;
    logic [7:0]     pad_bytes_reg;
    logic           flip_rows_reg;

    logic [DW-1:0]  col_cnt_reg, col_cnt_next;
    logic [DW-1:0]  row_cnt_reg, row_cnt_next;
    logic [7:0]     pad_rem_reg, pad_rem_next;

    logic [CDW-1:0] w, h;
    logic [CDW-1:0] col_eff, row_eff;
    logic [CDW-1:0] remain, col_end, row_inc, row_flip;
    logic [mbe_pkg::CNT_W-1:0] n;
    logic           row_done, last_row, in_pad, accept;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_format_reg <= 1'b0;
            image_width_reg  <= CDW'(8);
            image_height_reg <= CDW'(1);
            pad_bytes_reg    <= 8'd0;
            flip_rows_reg    <= 1'b0;
        end else if (cfg_we) begin
            case (mbe_pkg::reg_idx_t'(cfg_index))
                mbe_pkg::REG_COLOR_FORMAT: color_format_reg <= cfg_wdata[0];
                mbe_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[CDW-1:0];
                mbe_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[CDW-1:0];
                mbe_pkg::REG_PAD_BYTES:    pad_bytes_reg    <= cfg_wdata[7:0];
                mbe_pkg::REG_FLIP_ROWS:    flip_rows_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign color_format = color_format_reg;

    always_comb begin
        w = mbe_pkg::clamp_dim(image_width_reg);
        h = mbe_pkg::clamp_dim(image_height_reg);
        // stale counters after reconfiguration restart at zero
        col_eff = ({1'b0, col_cnt_reg} >= w) ? '0 : {1'b0, col_cnt_reg};
        row_eff = ({1'b0, row_cnt_reg} >= h) ? '0 : {1'b0, row_cnt_reg};
        remain  = w - col_eff;
        n       = (remain > CDW'(mbe_pkg::PIX_PER_BYTE)) ?
                  mbe_pkg::CNT_W'(mbe_pkg::PIX_PER_BYTE) : remain[mbe_pkg::CNT_W-1:0];
        col_end  = col_eff + CDW'(n);
        row_done = (col_end >= w);
        last_row = (row_eff == h - CDW'(1));
        row_inc  = row_eff + CDW'(1);
        row_flip = h - CDW'(1) - row_eff;
    end

    assign in_pad  = (pad_rem_reg != 8'd0);
    assign s_ready = in_pad || !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && !in_pad;

    always_comb begin
        q_wdata.src_bits   = s_source_byte;
        q_wdata.pix_count  = n;
        q_wdata.col_start  = col_eff[DW-1:0];
        q_wdata.row_out    = flip_rows_reg ? row_flip[DW-1:0] : row_eff[DW-1:0];
        q_wdata.frame_last = last_row && row_done;
    end

    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        pad_rem_next = pad_rem_reg;
        if (accept) begin
            if (in_pad) begin
                pad_rem_next = pad_rem_reg - 8'd1;
            end else if (row_done) begin
                col_cnt_next = '0;
                pad_rem_next = pad_bytes_reg;
                row_cnt_next = (row_inc >= h) ? '0 : row_inc[DW-1:0];
            end else begin
                col_cnt_next = col_end[DW-1:0];
                row_cnt_next = row_eff[DW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            pad_rem_reg <= '0;
        end else begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            pad_rem_reg <= pad_rem_next;
        end
    end

endmodule

`default_nettype wire

// File: design/mbe_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mbe_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire mbe_pkg::desc_t wdata,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output mbe_pkg::desc_t      rdata
);

    localparam int DEPTH = mbe_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mbe_pkg::desc_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rdata     = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: design/mbe_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mbe_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       color_format,
    input  wire logic                       q_not_empty,
    input  wire mbe_pkg::desc_t             q_rdata,
    output logic                            q_pop,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [15:0]                     m_pixel_value,
    output logic [mbe_pkg::DIM_W-1:0]       m_dest_row,
    output logic [mbe_pkg::DIM_W-1:0]       m_dest_col,
    output logic                            m_last_of_byte,
    output logic                            m_frame_end
);

    localparam int DW = mbe_pkg::DIM_W;
    localparam int NW = mbe_pkg::CNT_W;

    // pixel engine: walks one descriptor a pixel per cycle while the output register is free
    logic          eng_active_reg, eng_active_next;
    logic [7:0]    eng_bits_reg, eng_bits_next;
    logic [NW-1:0] eng_left_reg, eng_left_next;
    logic [DW-1:0] eng_col_reg, eng_col_next;
    logic [DW-1:0] eng_row_reg, eng_row_next;
    logic          eng_fl_reg, eng_fl_next;

    logic          m_valid_reg, m_valid_next;
    logic [15:0]   pix_reg, pix_next;
    logic [DW-1:0] row_reg, row_next;
    logic [DW-1:0] col_reg, col_next;
    logic          lob_reg, lob_next;
    logic          fe_reg, fe_next;

    logic out_free, emit, eng_done, eng_last;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = eng_active_reg && out_free;
    assign eng_last = (eng_left_reg == NW'(1));
    assign eng_done = emit && eng_last;
    assign q_pop    = q_not_empty && (!eng_active_reg || eng_done);

    always_comb begin
        eng_active_next = eng_active_reg;
        eng_bits_next   = eng_bits_reg;
        eng_left_next   = eng_left_reg;
        eng_col_next    = eng_col_reg;
        eng_row_next    = eng_row_reg;
        eng_fl_next     = eng_fl_reg;
        if (q_pop) begin
            eng_active_next = 1'b1;
            eng_bits_next   = q_rdata.src_bits;
            eng_left_next   = q_rdata.pix_count;
            eng_col_next    = q_rdata.col_start;
            eng_row_next    = q_rdata.row_out;
            eng_fl_next     = q_rdata.frame_last;
        end else if (eng_done) begin
            eng_active_next = 1'b0;
        end else if (emit) begin
            eng_bits_next = {eng_bits_reg[6:0], 1'b0};
            eng_left_next = eng_left_reg - NW'(1);
            eng_col_next  = eng_col_reg + DW'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        pix_next     = pix_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        lob_next     = lob_reg;
        fe_next      = fe_reg;
        if (out_free) begin
            m_valid_next = eng_active_reg;
            pix_next     = eng_bits_reg[7] ? mbe_pkg::COLOR_SET :
                           (color_format ? mbe_pkg::COLOR_CLEAR_1555
                                         : mbe_pkg::COLOR_CLEAR_565);
            row_next     = eng_row_reg;
            col_next     = eng_col_reg;
            lob_next     = eng_last;
            fe_next      = eng_last && eng_fl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eng_active_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            eng_active_reg <= eng_active_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        eng_bits_reg <= eng_bits_next;
        eng_left_reg <= eng_left_next;
        eng_col_reg  <= eng_col_next;
        eng_row_reg  <= eng_row_next;
        eng_fl_reg   <= eng_fl_next;
        pix_reg      <= pix_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        lob_reg      <= lob_next;
        fe_reg       <= fe_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_value  = pix_reg;
    assign m_dest_row     = row_reg;
    assign m_dest_col     = col_reg;
    assign m_last_of_byte = lob_reg;
    assign m_frame_end    = fe_reg;

endmodule

`default_nettype wire

// File: design/mono_bitmap_expander.sv
// Expands a stream of 1-bit-per-pixel source bytes (MSB first) into 16-bit pixels.
// Input channel s_*: one source byte per transaction. Output channel m_*: one pixel
// per transaction with its destination row/column, a last-of-byte flag and a
// frame-end flag on the last pixel of the last row.
// Configuration: cfg_we/cfg_index/cfg_wdata write color format, width, height,
// pad bytes and row flip; write only while the block is idle.
// A byte passes through the queue, the pixel engine and the output register before its first pixel is valid.
// Throughput: a data byte occupies the pixel engine until it has yielded its n pixels (n = 8
// except at the end of a row), so while m_ready stays high the output runs at one pixel per
// cycle; pad bytes are accepted without using the queue and produce nothing.
// The front classifier and the pixel engine are decoupled by a 4-entry queue, so
// input is taken while earlier bytes are still being expanded.
// Reset (aresetn low, synchronous) restores default configuration, clears the
// row/column/pad counters and empties the queue and output register.
// When m_ready is low the output holds; the queue fills and s_ready then drops.
`timescale 1ns / 1ps
`default_nettype none

module mono_bitmap_expander (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mbe_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_source_byte,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [15:0]                         m_pixel_value,
    output logic [mbe_pkg::DIM_W-1:0]           m_dest_row,
    output logic [mbe_pkg::DIM_W-1:0]           m_dest_col,
    output logic                                m_last_of_byte,
    output logic                                m_frame_end
);

    logic           color_format;
    logic           q_full, q_push, q_pop, q_not_empty;
    mbe_pkg::desc_t q_wdata, q_rdata;

    mbe_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_source_byte (s_source_byte),
        .color_format  (color_format),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    mbe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    mbe_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .color_format   (color_format),
        .q_not_empty    (q_not_empty),
        .q_rdata        (q_rdata),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_value  (m_pixel_value),
        .m_dest_row     (m_dest_row),
        .m_dest_col     (m_dest_col),
        .m_last_of_byte (m_last_of_byte),
        .m_frame_end    (m_frame_end)
    );

endmodule

`default_nettype wire
